@@ src/pdc_pkg.sv @@
`default_nettype none

package pdc_pkg;

   localparam int PosW      = 32;
   localparam int GainW     = 16;
   localparam int CntW      = 16;
   localparam int DutyW     = 8;
   localparam int DriveW    = 16;
   localparam int FracW     = 8;
   localparam int FracIdxW  = $clog2(FracW);
   localparam int ProdW     = PosW + GainW;
   localparam int DivW      = ProdW - FracW;
   localparam int DenW      = PosW;
   localparam int QuoW      = DivW + 1;
   localparam int SumW      = QuoW + 1;
   localparam int MulStepW  = $clog2(GainW);
   localparam int DivStepW  = $clog2(DivW);
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 16;

   localparam int DutyMax   = 255;
   localparam int DriveMax  = 32767;
   localparam int DriveMin  = -32768;

   localparam logic [CsrIdxW-1:0] CSR_KP_GAIN      = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_KD_GAIN      = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_ERR_THRESH   = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_SETTLE_COUNT = 2'd3;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_START  = 1'b1;

   typedef struct packed {
      logic                     start;
      logic signed [GainW-1:0]  kp;
      logic signed [GainW-1:0]  kd;
      logic signed [PosW-1:0]   err;
      logic signed [PosW-1:0]   dp;
      logic signed [PosW-1:0]   dt;
   } mul_arg_type;

   typedef struct packed {
      logic                     busy;
      logic signed [ProdW-1:0]  a;
      logic signed [ProdW-1:0]  b;
      logic signed [ProdW-1:0]  rdt;
   } mul_res_type;

   typedef struct packed {
      logic             start;
      logic [DivW-1:0]  dividend;
      logic [DenW-1:0]  divisor;
   } div_arg_type;

   typedef struct packed {
      logic             busy;
      logic [DivW-1:0]  quotient;
      logic             rem_nz;
   } div_res_type;

endpackage

`default_nettype wire

@@ src/pdc_ifs.sv @@
`default_nettype none

interface pdc_req_if;
   import pdc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic signed [PosW-1:0] enc_pos;
   logic signed [PosW-1:0] time_ms;
   logic signed [PosW-1:0] move_ticks;

   modport source (output valid, cmd, enc_pos, time_ms, move_ticks, input ready);
   modport sink   (input valid, cmd, enc_pos, time_ms, move_ticks, output ready);
endinterface

interface pdc_rsp_if;
   import pdc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     dir_forward;
   logic [DutyW-1:0]         duty;
   logic signed [DriveW-1:0] drive_value;
   logic                     done_res;

   modport source (output valid, dir_forward, duty, drive_value, done_res, input ready);
   modport sink   (input valid, dir_forward, duty, drive_value, done_res, output ready);
endinterface

`default_nettype wire

@@ src/pdc_mul.sv @@
`default_nettype none

module pdc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  pdc_pkg::mul_arg_type arg,
   output pdc_pkg::mul_res_type res
);
   import pdc_pkg::*;

   localparam logic [MulStepW-1:0] StepLast   = MulStepW'(GainW - 1);
   localparam logic [MulStepW-1:0] StepRStart = MulStepW'(FracW);

   logic                    busy_ff, busy_in;
   logic [MulStepW-1:0]     step_ff, step_in;
   logic [GainW-1:0]        mpa_ff, mpa_in;
   logic [GainW-1:0]        mpb_ff, mpb_in;
   logic signed [ProdW-1:0] mca_ff, mca_in;
   logic signed [ProdW-1:0] mcb_ff, mcb_in;
   logic signed [ProdW-1:0] mcr_ff, mcr_in;
   logic signed [ProdW-1:0] acc_a_ff, acc_a_in;
   logic signed [ProdW-1:0] acc_b_ff, acc_b_in;
   logic signed [ProdW-1:0] acc_r_ff, acc_r_in;

   logic last;
   logic r_phase;
   logic r_bit;

   assign last    = (step_ff == StepLast);
   assign r_phase = (step_ff >= StepRStart);
   assign r_bit   = acc_a_ff[step_ff[FracIdxW-1:0]];

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      mpa_in   = mpa_ff;
      mpb_in   = mpb_ff;
      mca_in   = mca_ff;
      mcb_in   = mcb_ff;
      mcr_in   = mcr_ff;
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      acc_r_in = acc_r_ff;
      if (arg.start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         mpa_in   = arg.kp;
         mpb_in   = arg.kd;
         mca_in   = {{(ProdW-PosW){arg.err[PosW-1]}}, arg.err};
         mcb_in   = {{(ProdW-PosW){arg.dp[PosW-1]}}, arg.dp};
         mcr_in   = {{(ProdW-PosW){arg.dt[PosW-1]}}, arg.dt};
         acc_a_in = '0;
         acc_b_in = '0;
         acc_r_in = '0;
      end else if (busy_ff) begin
         // top multiplier bit carries negative weight
         if (mpa_ff[0]) begin
            acc_a_in = last ? acc_a_ff - mca_ff : acc_a_ff + mca_ff;
         end
         if (mpb_ff[0]) begin
            acc_b_in = last ? acc_b_ff - mcb_ff : acc_b_ff + mcb_ff;
         end
         // low byte of a is final once the fraction bits have passed
         if (r_phase) begin
            if (r_bit) begin
               acc_r_in = acc_r_ff + mcr_ff;
            end
            mcr_in = mcr_ff <<< 1;
         end
         mca_in  = mca_ff <<< 1;
         mcb_in  = mcb_ff <<< 1;
         mpa_in  = mpa_ff >> 1;
         mpb_in  = mpb_ff >> 1;
         step_in = step_ff + MulStepW'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mpa_ff   <= mpa_in;
      mpb_ff   <= mpb_in;
      mca_ff   <= mca_in;
      mcb_ff   <= mcb_in;
      mcr_ff   <= mcr_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      acc_r_ff <= acc_r_in;
   end

   assign res.busy = busy_ff;
   assign res.a    = acc_a_ff;
   assign res.b    = acc_b_ff;
   assign res.rdt  = acc_r_ff;

endmodule

`default_nettype wire

@@ src/pdc_div.sv @@
`default_nettype none

module pdc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pdc_pkg::div_arg_type arg,
   output pdc_pkg::div_res_type res
);
   import pdc_pkg::*;

   localparam logic [DivStepW-1:0] StepLast = DivStepW'(DivW - 1);

   logic                busy_ff, busy_in;
   logic [DivStepW-1:0] step_ff, step_in;
   logic [DenW-1:0]     rem_ff, rem_in;
   logic [DivW-1:0]     quo_ff, quo_in;
   logic [DenW-1:0]     den_ff, den_in;

   logic [DenW:0] trial;
   logic [DenW:0] diff;
   logic          fits;

   assign trial = {rem_ff, quo_ff[DivW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (arg.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = arg.dividend;
         den_in  = arg.divisor;
      end else if (busy_ff) begin
         // shift one dividend bit in, one quotient bit out
         rem_in  = fits ? diff[DenW-1:0] : trial[DenW-1:0];
         quo_in  = {quo_ff[DivW-2:0], fits};
         step_in = step_ff + DivStepW'(1);
         if (step_ff == StepLast) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign res.busy     = busy_ff;
   assign res.quotient = quo_ff;
   assign res.rem_nz   = |rem_ff;

endmodule

`default_nettype wire

@@ src/pd_position_controller_top.sv @@
// channel  dir  handshake            word
// -------  ---  -------------------  ----------------------------------------
// req      in   req.valid/req.ready  cmd, enc_pos, time_ms, move_ticks
// rsp      out  rsp.valid/rsp.ready  dir_forward, duty, drive_value, done_res
// csr      in   csr_we (no wait)     csr_index, csr_wdata
//
// A start word gives no result.
// A sample word passes through a 16-step shift-add multiplier and a 40-step
// restoring divider; a settled sample goes straight to rsp and waits for neither.
// One word is in work at a time; the next is taken while a result waits in rsp.
// Reset is synchronous; it restores the gains, thresholds and position state.
`default_nettype none

module pd_position_controller_top (
   input  logic                          clock,
   input  logic                          reset,
   pdc_req_if.sink                       req,
   pdc_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [pdc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [pdc_pkg::CsrDataW-1:0]  csr_wdata
);
   import pdc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EVAL  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_PREP1 = 4'd3;
   localparam logic [3:0] S_PREP2 = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_FIN1  = 4'd6;
   localparam logic [3:0] S_FIN2  = 4'd7;
   localparam logic [3:0] S_FIN3  = 4'd8;
   localparam logic [3:0] S_PUT   = 4'd9;

   localparam logic signed [SumW-1:0] SumMax = SumW'(DriveMax);
   localparam logic signed [SumW-1:0] SumMin = SumW'(DriveMin);

   logic [3:0]               state_ff, state_in;
   logic signed [GainW-1:0]  kp_ff, kp_in;
   logic signed [GainW-1:0]  kd_ff, kd_in;
   logic [CntW-1:0]          thresh_ff, thresh_in;
   logic [CntW-1:0]          settle_ff, settle_in;
   logic [PosW-1:0]          target_ff, target_in;
   logic [PosW-1:0]          last_pos_ff, last_pos_in;
   logic [PosW-1:0]          last_time_ff, last_time_in;
   logic [CntW-1:0]          still_ff, still_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [PosW-1:0]   err_ff, err_in;
   logic signed [PosW-1:0]   dp_ff, dp_in;
   logic signed [PosW-1:0]   dt_ff, dt_in;
   logic                     same_ff, same_in;
   logic signed [ProdW-1:0]  m_ff, m_in;
   logic [DivW-1:0]          h_ff, h_in;
   logic [QuoW-1:0]          q_ff, q_in;
   logic                     rem_all_ff, rem_all_in;
   logic signed [SumW-1:0]   fl_ff, fl_in;
   logic signed [DriveW-1:0] drive_ff, drive_in;
   logic                     done_ff, done_in;

   logic                     dir_out_ff;
   logic [DutyW-1:0]         duty_out_ff;
   logic signed [DriveW-1:0] drive_out_ff;
   logic                     done_out_ff;

   mul_arg_type mul_arg;
   mul_res_type mul_res;
   div_arg_type div_arg;
   div_res_type div_res;

   logic                     req_take;
   logic                     rsp_load;
   logic [PosW-1:0]          err_abs;
   logic                     near;
   logic [DivW-1:0]          mq;
   logic                     m_neg;
   logic                     low_nz;
   logic [QuoW-1:0]          q_signed;
   logic signed [SumW-1:0]   fl_adj;
   logic [DriveW:0]          drive_abs;
   logic [DutyW-1:0]         duty_val;

   assign req.ready = (state_ff == S_IDLE);
   assign req_take  = req.valid && req.ready;

   assign err_abs = err_ff[PosW-1] ? (PosW'(0) - err_ff) : err_ff;
   assign near    = (err_abs < {{(PosW-CntW){1'b0}}, thresh_ff});

   assign mq     = m_ff[ProdW-1:FracW];
   assign m_neg  = m_ff[ProdW-1];
   assign low_nz = |m_ff[FracW-1:0];

   // floor of a negative quotient: -(Q + carry) = ~Q + !carry
   assign q_signed = m_neg ? (~{1'b0, div_res.quotient}) + QuoW'(!div_res.rem_nz)
                           : {1'b0, div_res.quotient};

   assign fl_adj = fl_ff + {{(SumW-1){1'b0}}, rem_all_ff && fl_ff[SumW-1]};

   assign drive_abs = drive_ff[DriveW-1] ? ((DriveW+1)'(0) - {drive_ff[DriveW-1], drive_ff})
                                         : {1'b0, drive_ff};
   assign duty_val  = (drive_abs > (DriveW+1)'(DutyMax)) ? DutyW'(DutyMax)
                                                         : drive_abs[DutyW-1:0];

   assign mul_arg.start = (state_ff == S_EVAL);
   assign mul_arg.kp    = kp_ff;
   assign mul_arg.kd    = kd_ff;
   assign mul_arg.err   = err_ff;
   assign mul_arg.dp    = dp_ff;
   assign mul_arg.dt    = dt_ff;

   assign div_arg.start    = (state_ff == S_PREP2);
   assign div_arg.dividend = mq[DivW-1] ? (DivW'(0) - mq) : mq;
   assign div_arg.divisor  = dt_ff[PosW-1] ? (DenW'(0) - dt_ff) : dt_ff;

   pdc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .arg   (mul_arg),
      .res   (mul_res)
   );

   pdc_div u_div (
      .clock (clock),
      .reset (reset),
      .arg   (div_arg),
      .res   (div_res)
   );

   always_comb begin
      state_in     = state_ff;
      kp_in        = kp_ff;
      kd_in        = kd_ff;
      thresh_in    = thresh_ff;
      settle_in    = settle_ff;
      target_in    = target_ff;
      last_pos_in  = last_pos_ff;
      last_time_in = last_time_ff;
      still_in     = still_ff;
      err_in       = err_ff;
      dp_in        = dp_ff;
      dt_in        = dt_ff;
      same_in      = same_ff;
      m_in         = m_ff;
      h_in         = h_ff;
      q_in         = q_ff;
      rem_all_in   = rem_all_ff;
      fl_in        = fl_ff;
      drive_in     = drive_ff;
      done_in      = done_ff;
      rsp_load     = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_KP_GAIN:      kp_in     = csr_wdata;
            CSR_KD_GAIN:      kd_in     = csr_wdata;
            CSR_ERR_THRESH:   thresh_in = csr_wdata;
            CSR_SETTLE_COUNT: settle_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req.cmd == CMD_START) begin
                  target_in    = req.enc_pos + req.move_ticks;
                  last_pos_in  = req.enc_pos + req.move_ticks;
                  last_time_in = PosW'(1);
                  still_in     = '0;
               end else begin
                  err_in       = target_ff - req.enc_pos;
                  dp_in        = req.enc_pos - last_pos_ff;
                  dt_in        = (req.time_ms == last_time_ff) ? PosW'(1)
                                                               : req.time_ms - last_time_ff;
                  same_in      = (req.enc_pos == last_pos_ff);
                  last_pos_in  = req.enc_pos;
                  last_time_in = req.time_ms;
                  state_in     = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            if (same_ff && near) begin
               still_in = (still_ff == '1) ? still_ff : still_ff + CntW'(1);
            end else begin
               still_in = '0;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            if (still_ff >= settle_ff) begin
               drive_in = '0;
               done_in  = 1'b1;
               state_in = S_PUT;
            end else if (!mul_res.busy) begin
               state_in = S_PREP1;
            end
         end
         S_PREP1: begin
            m_in     = dt_ff[PosW-1] ? (mul_res.b - mul_res.rdt) : (mul_res.rdt - mul_res.b);
            h_in     = mul_res.a[ProdW-1:FracW];
            state_in = S_PREP2;
         end
         S_PREP2: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!div_res.busy) begin
               state_in = S_FIN1;
            end
         end
         S_FIN1: begin
            q_in       = q_signed;
            rem_all_in = div_res.rem_nz || low_nz;
            state_in   = S_FIN2;
         end
         S_FIN2: begin
            fl_in    = {{(SumW-DivW){h_ff[DivW-1]}}, h_ff} + {q_ff[QuoW-1], q_ff};
            state_in = S_FIN3;
         end
         S_FIN3: begin
            if (fl_adj > SumMax) begin
               drive_in = DriveW'(DriveMax);
            end else if (fl_adj < SumMin) begin
               drive_in = DriveW'(DriveMin);
            end else begin
               drive_in = fl_adj[DriveW-1:0];
            end
            done_in  = 1'b0;
            state_in = S_PUT;
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kp_ff        <= GainW'(256);
         kd_ff        <= '0;
         thresh_ff    <= CntW'(10);
         settle_ff    <= CntW'(5);
         target_ff    <= '0;
         last_pos_ff  <= '0;
         last_time_ff <= PosW'(1);
         still_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kp_ff        <= kp_in;
         kd_ff        <= kd_in;
         thresh_ff    <= thresh_in;
         settle_ff    <= settle_in;
         target_ff    <= target_in;
         last_pos_ff  <= last_pos_in;
         last_time_ff <= last_time_in;
         still_ff     <= still_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      dp_ff      <= dp_in;
      dt_ff      <= dt_in;
      same_ff    <= same_in;
      m_ff       <= m_in;
      h_ff       <= h_in;
      q_ff       <= q_in;
      rem_all_ff <= rem_all_in;
      fl_ff      <= fl_in;
      drive_ff   <= drive_in;
      done_ff    <= done_in;
      if (rsp_load) begin
         dir_out_ff   <= !drive_ff[DriveW-1];
         duty_out_ff  <= duty_val;
         drive_out_ff <= drive_ff;
         done_out_ff  <= done_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.dir_forward = dir_out_ff;
   assign rsp.duty        = duty_out_ff;
   assign rsp.drive_value = drive_out_ff;
   assign rsp.done_res    = done_out_ff;

endmodule

`default_nettype wire

@@ src/pdc_checker.sv @@
`default_nettype none

module pdc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_cmd,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_dir_forward,
   input logic [pdc_pkg::DutyW-1:0]            rsp_duty,
   input logic signed [pdc_pkg::DriveW-1:0]    rsp_drive_value,
   input logic                                 rsp_done_res
);
   import pdc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_value)
                                  && $stable(rsp_done_res) && $stable(rsp_duty))
      else $error("rsp word changed while stalled");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_drive_value == '0 && rsp_duty == '0
                                    && rsp_dir_forward)
      else $error("done word carries a nonzero drive");

   a_duty_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_drive_value[DriveW-1:DutyW] == '0)
         |-> rsp_duty == rsp_drive_value[DutyW-1:0] && rsp_dir_forward)
      else $error("duty does not follow a small positive drive");

   a_start_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_START) |=> req_ready)
      else $error("start word did not finish in one cycle");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_SAMPLE) |=> !req_ready)
      else $error("sample word did not hold off the next word");

endmodule

bind pd_position_controller_top pdc_checker u_pdc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_cmd         (req.cmd),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_dir_forward (rsp.dir_forward),
   .rsp_duty        (rsp.duty),
   .rsp_drive_value (rsp.drive_value),
   .rsp_done_res    (rsp.done_res)
);

`default_nettype wire

@@ bench/pd_position_controller_top_tb.sv @@
`timescale 1ns / 1ps

module pd_position_controller_top_tb;
   import pdc_pkg::*;

   localparam int CycleLimit = 1_000_000;
   localparam int DrainCycles = 80;

   typedef struct packed {
      logic                     dir_forward;
      logic [DutyW-1:0]         duty;
      logic signed [DriveW-1:0] drive_value;
      logic                     done_res;
   } motor_drive_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   pdc_req_if req_bus ();
   pdc_rsp_if rsp_bus ();

   pd_position_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // controller copy: gains, limits and position state
   logic signed [GainW-1:0] kp_cfg = 16'sd256;
   logic signed [GainW-1:0] kd_cfg = 16'sd0;
   logic [CntW-1:0]         thresh_cfg = 16'd10;
   logic [CntW-1:0]         settle_cfg = 16'd5;
   logic signed [PosW-1:0]  goal_pos = '0;
   logic signed [PosW-1:0]  prev_pos = '0;
   logic signed [PosW-1:0]  prev_ms = 32'sd1;
   logic [CntW-1:0]         still_run = '0;

   motor_drive_type drive_expect_q[$];
   motor_drive_type drive_head;
   int unsigned     mismatches = 0;
   int unsigned     cycle_count = 0;
   int unsigned     words_sent = 0;
   bit              steady_run = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("pd_position_controller_top_tb failed");
         $finish;
      end
   end

   task automatic track_position(input logic cmd, input logic signed [PosW-1:0] enc,
                                 input logic signed [PosW-1:0] tim,
                                 input logic signed [PosW-1:0] mov);
      logic signed [PosW-1:0] err;
      logic signed [PosW-1:0] dp;
      logic signed [PosW-1:0] dt;
      logic [PosW-1:0]        mag;
      logic signed [127:0]    num;
      logic signed [127:0]    den;
      logic signed [127:0]    quo;
      int                     drv;
      int                     drv_mag;
      motor_drive_type        res;
      if (cmd == CMD_START) begin
         goal_pos = enc + mov;
         still_run = '0;
         prev_pos = goal_pos;
         prev_ms = 32'sd1;
      end else begin
         err = goal_pos - enc;
         dp = enc - prev_pos;
         dt = tim - prev_ms;
         if (dt == 0) dt = 32'sd1;
         mag = (err < 0) ? -err : err;
         if (enc == prev_pos && mag < thresh_cfg) begin
            if (still_run != '1) still_run = still_run + 1'b1;
         end else begin
            still_run = '0;
         end
         res.done_res = 1'b0;
         if (still_run < settle_cfg) begin
            num = kp_cfg * err;
            num = num * dt - kd_cfg * dp;
            den = dt * (2 ** FracW);
            quo = num / den;
            if (quo > DriveMax) drv = DriveMax;
            else if (quo < DriveMin) drv = DriveMin;
            else drv = int'(quo);
         end else begin
            drv = 0;
            res.done_res = 1'b1;
         end
         prev_pos = enc;
         prev_ms = tim;
         drv_mag = (drv < 0) ? -drv : drv;
         res.dir_forward = (drv >= 0);
         res.duty = (drv_mag > DutyMax) ? DutyW'(DutyMax) : DutyW'(drv_mag);
         res.drive_value = DriveW'(drv);
         drive_expect_q.push_back(res);
      end
   endtask

   task automatic send_word(input logic cmd, input logic [PosW-1:0] enc,
                            input logic [PosW-1:0] tim, input logic [PosW-1:0] mov);
      while (!steady_run && $urandom_range(99) < 9) @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.cmd = cmd;
      req_bus.enc_pos = enc;
      req_bus.time_ms = tim;
      req_bus.move_ticks = mov;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track_position(cmd, enc, tim, mov);
      words_sent++;
      @(negedge clock);
      req_bus.valid = 1'b0;
      req_bus.cmd = 1'($urandom);
      req_bus.enc_pos = $urandom;
      req_bus.time_ms = $urandom;
      req_bus.move_ticks = $urandom;
   endtask

   // hold until every result is back; a start word gives no result to wait for
   task automatic drain();
      while (drive_expect_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      csr_index = 2'($urandom);
      csr_wdata = 16'($urandom);
      case (idx)
         CSR_KP_GAIN:      kp_cfg = data;
         CSR_KD_GAIN:      kd_cfg = data;
         CSR_ERR_THRESH:   thresh_cfg = data;
         CSR_SETTLE_COUNT: settle_cfg = data;
         default:          ;
      endcase
   endtask

   task automatic load_gains(input logic [15:0] kp, input logic [15:0] kd,
                             input logic [15:0] thr, input logic [15:0] settle);
      drain();
      write_csr(CSR_KP_GAIN, kp);
      write_csr(CSR_KD_GAIN, kd);
      write_csr(CSR_ERR_THRESH, thr);
      write_csr(CSR_SETTLE_COUNT, settle);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      rsp_bus.ready = steady_run || ($urandom_range(99) >= 9);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (drive_expect_q.size() == 0) begin
            $display("%0t: unexpected word expected none actual drive %0d", $time,
                     rsp_bus.drive_value);
            mismatches++;
         end else begin
            drive_head = drive_expect_q.pop_front();
            check_field("dir_forward", drive_head.dir_forward, rsp_bus.dir_forward);
            check_field("duty", drive_head.duty, rsp_bus.duty);
            check_field("drive_value", $signed(drive_head.drive_value),
                        $signed(rsp_bus.drive_value));
            check_field("done_res", drive_head.done_res, rsp_bus.done_res);
         end
      end
   end

   task automatic test_reset_settle();
      repeat (6) send_word(CMD_SAMPLE, 32'd0, 32'd1, $urandom);
   endtask

   task automatic test_field_extremes();
      load_gains(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
      send_word(CMD_START, 32'h7FFF_FFFF, $urandom, 32'd1);
      send_word(CMD_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      send_word(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_word(CMD_SAMPLE, 32'h0, 32'h8000_0000, 32'h0);
      send_word(CMD_SAMPLE, 32'h0, 32'd5, 32'h0);
      send_word(CMD_SAMPLE, 32'h0000_1000, 32'd3, 32'h0);
      send_word(CMD_START, 32'h8000_0000, $urandom, 32'hFFFF_FFFF);
      send_word(CMD_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      load_gains(16'h8000, 16'h7FFF, 16'd1, 16'd2);
      send_word(CMD_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h0, 32'h0);
      send_word(CMD_SAMPLE, 32'h1234_5678, 32'h0000_FFFF, 32'h0);
   endtask

   task automatic test_settle_zero();
      load_gains(16'd256, 16'd0, 16'd0, 16'd0);
      send_word(CMD_SAMPLE, $urandom, $urandom, $urandom);
      send_word(CMD_SAMPLE, $urandom, $urandom, $urandom);
      load_gains(16'd256, 16'd0, 16'd0, 16'd1);
      send_word(CMD_SAMPLE, 32'd77, 32'd100, 32'd0);
      send_word(CMD_SAMPLE, 32'd77, 32'd101, 32'd0);
   endtask

   // start, approach the goal, then sit near it so that it may settle
   task automatic run_move();
      logic signed [PosW-1:0] pos;
      logic signed [PosW-1:0] goal;
      logic signed [PosW-1:0] ms;
      logic signed [PosW-1:0] move;
      logic signed [PosW-1:0] step;
      logic signed [PosW-1:0] offset;
      int unsigned            legs;
      int unsigned            hold;
      int unsigned            reach;
      pos = $urandom;
      move = ($urandom_range(9) < 7) ? 32'($urandom_range(4000)) - 32'd2000 : $urandom;
      goal = pos + move;
      ms = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
      send_word(CMD_START, pos, $urandom, move);
      legs = $urandom_range(1, 6);
      repeat (legs) begin
         step = goal - pos;
         pos = pos + (step >>> 1);
         ms = ms + $urandom_range(25);
         send_word(CMD_SAMPLE, pos, ms, $urandom);
      end
      reach = (thresh_cfg > 16'd41) ? 40 : ((thresh_cfg > 0) ? thresh_cfg - 1 : 0);
      offset = $urandom_range(reach);
      if ($urandom_range(1)) offset = -offset;
      pos = goal + offset;
      hold = ((settle_cfg < 16'd12) ? settle_cfg : 12) + $urandom_range(3);
      repeat (hold) begin
         if ($urandom_range(19) == 0) pos = pos + 1;
         ms = ms + $urandom_range(3);
         send_word(CMD_SAMPLE, pos, ms, $urandom);
      end
   endtask

   task automatic test_tracking_moves(input logic [15:0] kp, input logic [15:0] kd,
                                      input logic [15:0] thr, input logic [15:0] settle,
                                      input int unsigned count);
      int unsigned first;
      load_gains(kp, kd, thr, settle);
      first = words_sent;
      while (words_sent - first < count) run_move();
   endtask

   task automatic test_steady_stream();
      steady_run = 1'b1;
      test_tracking_moves(16'd512, 16'd128, 16'd20, 16'd3, 200);
      drain();
      steady_run = 1'b0;
   endtask

   task automatic test_random_words(input int unsigned count);
      load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(3)));
      repeat (count) begin
         send_word(($urandom_range(9) == 0) ? CMD_START : CMD_SAMPLE,
                   $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_SAMPLE;
      req_bus.enc_pos = '0;
      req_bus.time_ms = '0;
      req_bus.move_ticks = '0;
      rsp_bus.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_settle();
      test_field_extremes();
      test_settle_zero();
      test_tracking_moves(16'd256, 16'd0, 16'd10, 16'd5, 240);
      test_tracking_moves(16'($urandom_range(4000) - 2000), 16'($urandom_range(4000) - 2000),
                          16'd3, 16'd2, 240);
      test_tracking_moves(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd1, 240);
      test_tracking_moves(16'h8000, 16'h8000, 16'd1, 16'd0, 240);
      test_tracking_moves(16'($urandom), 16'($urandom), 16'($urandom_range(64)),
                          16'($urandom_range(8)), 240);
      test_steady_stream();
      test_random_words(300);

      drain();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("pd_position_controller_top_tb passed");
      end else begin
         $display("pd_position_controller_top_tb failed");
      end
      $finish;
   end

endmodule
